// ===== rtl/gopa_pkg.sv =====
// Shared types, codes and constants of the gradient outer-product accumulator.
package gopa_pkg;

    localparam int MAX_SRC_DEF = 64;
    localparam int MAX_DST_DEF = 64;

    localparam int IDX_W   = 6;
    localparam int VAL_W   = 16;
    localparam int SUM_W   = 17;
    localparam int PROD_W  = 33;
    localparam int ACC_W   = 40;
    localparam int CNT7_W  = 7;
    localparam int SEL_W   = 4;
    localparam int APB_AW  = 4;
    localparam int APB_DW  = 32;

    localparam logic [1:0] REQ_LOAD = 2'd0;
    localparam logic [1:0] REQ_ACC  = 2'd1;
    localparam logic [1:0] REQ_READ = 2'd2;

    localparam logic [1:0] REG_SRC_COUNT  = 2'd0;
    localparam logic [1:0] REG_DST_COUNT  = 2'd1;
    localparam logic [1:0] REG_OMIT_EN    = 2'd2;
    localparam logic [1:0] REG_OMIT_SEL   = 2'd3;

    localparam logic [CNT7_W-1:0] SRC_COUNT_RST = 7'd64;
    localparam logic [CNT7_W-1:0] DST_COUNT_RST = 7'd64;

    typedef struct packed {
        logic [CNT7_W-1:0] src_count;
        logic [CNT7_W-1:0] dst_count;
        logic              omit_enable;
        logic [SEL_W-1:0]  omit_bit_select;
    } cfg_t;

endpackage

// ===== rtl/gopa_if.sv =====
// Request and response channel interfaces of the gradient accumulator.
interface gopa_req_if;
    logic                                valid;
    logic                                ready;
    logic [1:0]                          req_type;
    logic [gopa_pkg::IDX_W-1:0]          src_index;
    logic [gopa_pkg::IDX_W-1:0]          dst_index;
    logic signed [gopa_pkg::VAL_W-1:0]   sample_value;
    logic signed [gopa_pkg::VAL_W-1:0]   src_offset;
    logic [gopa_pkg::VAL_W-1:0]          omit_flags;
    logic                                clear_after_read;

    modport source (
        output valid, req_type, src_index, dst_index, sample_value, src_offset,
               omit_flags, clear_after_read,
        input  ready
    );
    modport sink (
        input  valid, req_type, src_index, dst_index, sample_value, src_offset,
               omit_flags, clear_after_read,
        output ready
    );
endinterface

interface gopa_rsp_if;
    logic                                valid;
    logic                                ready;
    logic signed [gopa_pkg::ACC_W-1:0]   grad_value;
    logic [gopa_pkg::IDX_W-1:0]          read_src;
    logic [gopa_pkg::IDX_W-1:0]          read_dst;

    modport source (
        output valid, grad_value, read_src, read_dst,
        input  ready
    );
    modport sink (
        input  valid, grad_value, read_src, read_dst,
        output ready
    );
endinterface

// ===== rtl/gopa_apb_regs.sv =====
// APB configuration register file of the gradient accumulator.
module gopa_apb_regs (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [gopa_pkg::APB_AW-1:0]     paddr,
    input  logic [gopa_pkg::APB_DW-1:0]     pwdata,
    output logic [gopa_pkg::APB_DW-1:0]     prdata,
    output logic                            pready,
    output gopa_pkg::cfg_t                  cfg
);

    gopa_pkg::cfg_t cfg_reg;
    logic           wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    assign cfg    = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.src_count       <= gopa_pkg::SRC_COUNT_RST;
            cfg_reg.dst_count       <= gopa_pkg::DST_COUNT_RST;
            cfg_reg.omit_enable     <= 1'b0;
            cfg_reg.omit_bit_select <= '0;
        end
        else if (wr_en)
        begin
            unique case (paddr[3:2])
                gopa_pkg::REG_SRC_COUNT: cfg_reg.src_count <= pwdata[gopa_pkg::CNT7_W-1:0];
                gopa_pkg::REG_DST_COUNT: cfg_reg.dst_count <= pwdata[gopa_pkg::CNT7_W-1:0];
                gopa_pkg::REG_OMIT_EN:   cfg_reg.omit_enable <= pwdata[0];
                gopa_pkg::REG_OMIT_SEL:
                    cfg_reg.omit_bit_select <= pwdata[gopa_pkg::SEL_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[3:2])
            gopa_pkg::REG_SRC_COUNT: prdata = gopa_pkg::APB_DW'(cfg_reg.src_count);
            gopa_pkg::REG_DST_COUNT: prdata = gopa_pkg::APB_DW'(cfg_reg.dst_count);
            gopa_pkg::REG_OMIT_EN:   prdata = gopa_pkg::APB_DW'(cfg_reg.omit_enable);
            gopa_pkg::REG_OMIT_SEL:  prdata = gopa_pkg::APB_DW'(cfg_reg.omit_bit_select);
            default:                 prdata = '0;
        endcase
    end

endmodule

// ===== rtl/gopa_ram.sv =====
// Simple dual-port synchronous RAM with registered read data.
module gopa_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    assign rdata = rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

endmodule

// ===== rtl/gopa_engine.sv =====
// Request sequencer with gradient and derivative stores and the MAC pipeline.
module gopa_engine #(
    parameter int MAX_SRC = gopa_pkg::MAX_SRC_DEF,
    parameter int MAX_DST = gopa_pkg::MAX_DST_DEF
) (
    input  logic            clk,
    input  logic            rst_n,
    input  gopa_pkg::cfg_t  cfg,
    gopa_req_if.sink        req,
    gopa_rsp_if.source      rsp
);

    localparam int DEPTH   = MAX_SRC * MAX_DST;
    localparam int ADDR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int DST_AW  = (MAX_DST > 1) ? $clog2(MAX_DST) : 1;
    localparam int CNT_W   = $clog2(MAX_DST + 1);
    localparam int ACC_W   = gopa_pkg::ACC_W;
    localparam int VAL_W   = gopa_pkg::VAL_W;
    localparam int SUM_W   = gopa_pkg::SUM_W;
    localparam int PROD_W  = gopa_pkg::PROD_W;
    localparam int IDX_W   = gopa_pkg::IDX_W;

    localparam logic [2:0] ST_CLEAR   = 3'd0;
    localparam logic [2:0] ST_IDLE    = 3'd1;
    localparam logic [2:0] ST_ACC     = 3'd2;
    localparam logic [2:0] ST_RD_ADDR = 3'd3;
    localparam logic [2:0] ST_RD_DATA = 3'd4;
    localparam logic [2:0] ST_RD_OUT  = 3'd5;

    localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(DEPTH - 1);

    logic [2:0]               state_reg, state_next;
    logic [ADDR_W-1:0]        clr_addr_reg, clr_addr_next;
    logic [CNT_W-1:0]         col_reg, col_next;
    logic [CNT_W-1:0]         ncol_reg, ncol_next;
    logic [ADDR_W-1:0]        base_reg, base_next;
    logic signed [SUM_W-1:0]  tv_reg, tv_next;
    logic                     p1_valid_reg, p1_valid_next;
    logic                     p2_valid_reg, p2_valid_next;
    logic [ADDR_W-1:0]        p1_addr_reg;
    logic [ADDR_W-1:0]        p2_addr_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [ACC_W-1:0]  acc_q_reg;
    logic [ADDR_W-1:0]        rd_addr_reg, rd_addr_next;
    logic                     rd_ok_reg, rd_ok_next;
    logic                     rd_clr_reg, rd_clr_next;
    logic [IDX_W-1:0]         rd_src_reg, rd_src_next;
    logic [IDX_W-1:0]         rd_dst_reg, rd_dst_next;
    logic signed [ACC_W-1:0]  hold_reg;
    logic                     out_valid_reg, out_valid_next;
    logic signed [ACC_W-1:0]  out_value_reg;
    logic [IDX_W-1:0]         out_src_reg;
    logic [IDX_W-1:0]         out_dst_reg;

    logic                     accept;
    logic                     issue;
    logic                     out_load;
    logic [31:0]              src_lim;
    logic [31:0]              dst_lim;
    logic                     row_ok;
    logic                     omitted;
    logic [ADDR_W-1:0]        issue_addr;
    logic signed [ACC_W:0]    sum_wide;
    logic signed [ACC_W-1:0]  sum_sat;

    logic                     g_we, g_re;
    logic [ADDR_W-1:0]        g_waddr, g_raddr;
    logic [ACC_W-1:0]         g_wdata, g_rdata;
    logic                     d_we, d_re;
    logic [DST_AW-1:0]        d_waddr, d_raddr;
    logic [VAL_W-1:0]         d_rdata;

    gopa_ram #(.WIDTH(ACC_W), .DEPTH(DEPTH), .AW(ADDR_W)) u_grad_ram (
        .clk   (clk),
        .we    (g_we),
        .waddr (g_waddr),
        .wdata (g_wdata),
        .re    (g_re),
        .raddr (g_raddr),
        .rdata (g_rdata)
    );

    gopa_ram #(.WIDTH(VAL_W), .DEPTH(MAX_DST), .AW(DST_AW)) u_deriv_ram (
        .clk   (clk),
        .we    (d_we),
        .waddr (d_waddr),
        .wdata (req.sample_value),
        .re    (d_re),
        .raddr (d_raddr),
        .rdata (d_rdata)
    );

    assign req.ready      = (state_reg == ST_IDLE);
    assign accept         = req.valid && req.ready;
    assign rsp.valid      = out_valid_reg;
    assign rsp.grad_value = out_value_reg;
    assign rsp.read_src   = out_src_reg;
    assign rsp.read_dst   = out_dst_reg;

    assign src_lim = (32'(cfg.src_count) > 32'(MAX_SRC)) ? 32'(MAX_SRC) : 32'(cfg.src_count);
    assign dst_lim = (32'(cfg.dst_count) > 32'(MAX_DST)) ? 32'(MAX_DST) : 32'(cfg.dst_count);
    assign row_ok  = 32'(req.src_index) < src_lim;
    assign omitted = cfg.omit_enable && req.omit_flags[cfg.omit_bit_select];

    assign issue      = (state_reg == ST_ACC) && (col_reg < ncol_reg);
    assign issue_addr = ADDR_W'(32'(base_reg) + 32'(col_reg));
    assign out_load   = (state_reg == ST_RD_OUT) && (!out_valid_reg || rsp.ready);

    assign sum_wide = {acc_q_reg[ACC_W-1], acc_q_reg} + (ACC_W + 1)'(prod_reg);
    always_comb
    begin
        if (sum_wide[ACC_W] != sum_wide[ACC_W-1])
        begin
            sum_sat = sum_wide[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
        end
        else
        begin
            sum_sat = sum_wide[ACC_W-1:0];
        end
    end

    assign d_we    = accept && (req.req_type == gopa_pkg::REQ_LOAD)
                     && (32'(req.dst_index) < 32'(MAX_DST));
    assign d_waddr = DST_AW'(req.dst_index);
    assign d_re    = issue;
    assign d_raddr = col_reg[DST_AW-1:0];

    always_comb
    begin
        g_we    = 1'b0;
        g_waddr = p2_addr_reg;
        g_wdata = sum_sat;
        g_re    = 1'b0;
        g_raddr = issue_addr;
        unique case (state_reg)
            ST_CLEAR:
            begin
                g_we    = 1'b1;
                g_waddr = clr_addr_reg;
                g_wdata = '0;
            end
            ST_ACC:
            begin
                g_we = p2_valid_reg;
                g_re = issue;
            end
            ST_RD_ADDR:
            begin
                g_re    = 1'b1;
                g_raddr = rd_addr_reg;
            end
            ST_RD_DATA:
            begin
                g_we    = rd_clr_reg && rd_ok_reg;
                g_waddr = rd_addr_reg;
                g_wdata = '0;
            end
            default: ;
        endcase
    end

    always_comb
    begin
        state_next    = state_reg;
        clr_addr_next = clr_addr_reg;
        col_next      = col_reg;
        ncol_next     = ncol_reg;
        base_next     = base_reg;
        tv_next       = tv_reg;
        rd_addr_next  = rd_addr_reg;
        rd_ok_next    = rd_ok_reg;
        rd_clr_next   = rd_clr_reg;
        rd_src_next   = rd_src_reg;
        rd_dst_next   = rd_dst_reg;
        p1_valid_next = issue;
        p2_valid_next = p1_valid_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                clr_addr_next = clr_addr_reg + ADDR_W'(1);
                if (clr_addr_reg == LAST_ADDR)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    unique case (req.req_type)
                        gopa_pkg::REQ_ACC:
                        begin
                            col_next  = '0;
                            ncol_next = CNT_W'(dst_lim);
                            base_next = ADDR_W'(32'(req.src_index) * 32'(MAX_DST));
                            tv_next   = SUM_W'(req.sample_value) + SUM_W'(req.src_offset);
                            if (row_ok && !omitted)
                            begin
                                state_next = ST_ACC;
                            end
                        end
                        gopa_pkg::REQ_READ:
                        begin
                            rd_ok_next   = (32'(req.src_index) < 32'(MAX_SRC))
                                           && (32'(req.dst_index) < 32'(MAX_DST));
                            rd_addr_next = ADDR_W'(32'(req.src_index) * 32'(MAX_DST)
                                                   + 32'(req.dst_index));
                            rd_clr_next  = req.clear_after_read;
                            rd_src_next  = req.src_index;
                            rd_dst_next  = req.dst_index;
                            state_next   = ST_RD_ADDR;
                        end
                        default: ;
                    endcase
                end
            end
            ST_ACC:
            begin
                if (issue)
                begin
                    col_next = col_reg + CNT_W'(1);
                end
                else if (!p1_valid_reg && !p2_valid_reg)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_RD_ADDR:
            begin
                state_next = ST_RD_DATA;
            end
            ST_RD_DATA:
            begin
                state_next = ST_RD_OUT;
            end
            ST_RD_OUT:
            begin
                if (out_load)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_addr_reg  <= '0;
            col_reg       <= '0;
            ncol_reg      <= '0;
            p1_valid_reg  <= 1'b0;
            p2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_addr_reg  <= clr_addr_next;
            col_reg       <= col_next;
            ncol_reg      <= ncol_next;
            p1_valid_reg  <= p1_valid_next;
            p2_valid_reg  <= p2_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        base_reg    <= base_next;
        tv_reg      <= tv_next;
        rd_addr_reg <= rd_addr_next;
        rd_ok_reg   <= rd_ok_next;
        rd_clr_reg  <= rd_clr_next;
        rd_src_reg  <= rd_src_next;
        rd_dst_reg  <= rd_dst_next;
        p1_addr_reg <= issue_addr;
        p2_addr_reg <= p1_addr_reg;
        prod_reg    <= PROD_W'(tv_reg) * PROD_W'($signed(d_rdata));
        acc_q_reg   <= $signed(g_rdata);
        if (state_reg == ST_RD_DATA)
        begin
            hold_reg <= rd_ok_reg ? $signed(g_rdata) : '0;
        end
        if (out_load)
        begin
            out_value_reg <= hold_reg;
            out_src_reg   <= rd_src_reg;
            out_dst_reg   <= rd_dst_reg;
        end
    end

endmodule

// ===== rtl/gradient_outer_product_accumulate_core.sv =====
// Top level of the gradient outer-product accumulator.
//
// Requests enter on the req channel and read results leave on the rsp
// channel; both transfer when valid and ready are high at a rising edge.
// Registers are written over the APB port while no request is in flight;
// the user must keep to this, as the block does not enforce it.
// Load derivative: no result. Accumulate row: a multiply-accumulate for
// each of dst_count columns through the gradient RAM read-modify-write
// pipeline; an omitted or out-of-range row is dropped. No result.
// Read entry: one RAM read, then the result enters the output register;
// with clear_after_read the entry is zeroed in the same pass.
// After reset the gradient RAM is cleared, one entry a cycle, all
// MAX_SRC * MAX_DST entries (4096 by default), before req.ready rises.
// A stalled receiver holds the result in the output register; the next
// load or accumulate is still taken, a further read waits for the slot.
module gradient_outer_product_accumulate_core #(
    parameter int MAX_SRC = gopa_pkg::MAX_SRC_DEF,
    parameter int MAX_DST = gopa_pkg::MAX_DST_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    gopa_req_if.sink                     req,
    gopa_rsp_if.source                   rsp,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [gopa_pkg::APB_AW-1:0]  paddr,
    input  logic [gopa_pkg::APB_DW-1:0]  pwdata,
    output logic [gopa_pkg::APB_DW-1:0]  prdata,
    output logic                         pready
);

    gopa_pkg::cfg_t cfg;

    gopa_apb_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    gopa_engine #(.MAX_SRC(MAX_SRC), .MAX_DST(MAX_DST)) u_engine (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg),
        .req   (req),
        .rsp   (rsp)
    );

endmodule
